// File: sv/srjl_pkg.sv
// ----------------------------------------------------------------------------
// srjl_pkg
// Shared constants, codes and types for the sorted range join lookup.
// ----------------------------------------------------------------------------
package srjl_pkg;

   localparam int MAX_RANGES = 1024;
   localparam int ADDR_W     = $clog2(MAX_RANGES);
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);
   localparam int DATA_W     = 32;
   localparam int KIND_W     = 2;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_CMP   = 4'b0100,
      ST_DONE  = 4'b1000
   } walk_state_type;

   typedef struct packed {
      logic                     en;
      logic [ADDR_W-1:0]        addr;
      logic signed [DATA_W-1:0] lower;
      logic signed [DATA_W-1:0] upper;
      logic signed [DATA_W-1:0] value;
   } tbl_wr_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] lower;
      logic signed [DATA_W-1:0] upper;
      logic signed [DATA_W-1:0] value;
   } tbl_rd_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
      logic                     found;
   } walk_res_type;

endpackage

// File: sv/srjl_table.sv
// ----------------------------------------------------------------------------
// srjl_table
// Range table storage: lower bound, upper bound and attached value memories,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module srjl_table (
   input  logic                       clock,
   input  srjl_pkg::tbl_wr_type       wr,
   input  logic [srjl_pkg::ADDR_W-1:0] rd_addr,
   output srjl_pkg::tbl_rd_type       rd
);

   logic signed [srjl_pkg::DATA_W-1:0] lower_mem [srjl_pkg::MAX_RANGES];
   logic signed [srjl_pkg::DATA_W-1:0] upper_mem [srjl_pkg::MAX_RANGES];
   logic signed [srjl_pkg::DATA_W-1:0] value_mem [srjl_pkg::MAX_RANGES];

   srjl_pkg::tbl_rd_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         lower_mem[wr.addr] <= wr.lower;
         upper_mem[wr.addr] <= wr.upper;
         value_mem[wr.addr] <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff.lower <= lower_mem[rd_addr];
      rd_ff.upper <= upper_mem[rd_addr];
      rd_ff.value <= value_mem[rd_addr];
   end

   assign rd = rd_ff;

endmodule

// File: sv/srjl_walk.sv
// ----------------------------------------------------------------------------
// srjl_walk
// Command sequencer and walk engine: handles clear and append, and for a probe
// steps the walk pointer through the table with a lower and an upper bound comparator.
// ----------------------------------------------------------------------------
module srjl_walk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  logic [srjl_pkg::KIND_W-1:0]        cmd_kind,
   input  logic signed [srjl_pkg::DATA_W-1:0] cmd_lower,
   input  logic signed [srjl_pkg::DATA_W-1:0] cmd_upper,
   input  logic signed [srjl_pkg::DATA_W-1:0] cmd_value,
   input  logic signed [srjl_pkg::DATA_W-1:0] cmd_key,
   input  logic                               use_from_value,
   output srjl_pkg::tbl_wr_type               tbl_wr,
   output logic [srjl_pkg::ADDR_W-1:0]        tbl_rd_addr,
   input  srjl_pkg::tbl_rd_type               tbl_rd,
   output srjl_pkg::walk_res_type             res,
   input  logic                               res_ack
);

   srjl_pkg::walk_state_type state_ff, state_in;
   logic [srjl_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [srjl_pkg::CNT_W-1:0]        ptr_ff, ptr_in;
   logic signed [srjl_pkg::DATA_W-1:0] key_ff, key_in;
   logic signed [srjl_pkg::DATA_W-1:0] rval_ff, rval_in;
   logic                               found_ff, found_in;

   logic cmd_xfer;
   logic below_lower;
   logic below_upper;
   logic [srjl_pkg::DATA_W-1:0] ptr_ext;

   assign cmd_ready   = (state_ff == srjl_pkg::ST_IDLE);
   assign cmd_xfer    = cmd_valid && cmd_ready;
   assign tbl_rd_addr = ptr_ff[srjl_pkg::ADDR_W-1:0];
   assign below_lower = key_ff < tbl_rd.lower;
   assign below_upper = key_ff < tbl_rd.upper;
   assign ptr_ext     = {{(srjl_pkg::DATA_W-srjl_pkg::CNT_W){1'b0}}, ptr_ff};

   always_comb begin
      tbl_wr.en    = cmd_xfer && (cmd_kind == srjl_pkg::KIND_APPEND)
                     && (count_ff < srjl_pkg::CNT_W'(srjl_pkg::MAX_RANGES));
      tbl_wr.addr  = count_ff[srjl_pkg::ADDR_W-1:0];
      tbl_wr.lower = cmd_lower;
      tbl_wr.upper = cmd_upper;
      tbl_wr.value = cmd_value;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      key_in   = key_ff;
      rval_in  = rval_ff;
      found_in = found_ff;
      unique case (state_ff)
         srjl_pkg::ST_IDLE: begin
            if (cmd_xfer) begin
               unique case (cmd_kind)
                  srjl_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     ptr_in   = '0;
                  end
                  srjl_pkg::KIND_APPEND: begin
                     if (tbl_wr.en) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  srjl_pkg::KIND_PROBE: begin
                     key_in   = cmd_key;
                     state_in = srjl_pkg::ST_FETCH;
                  end
                  srjl_pkg::KIND_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         srjl_pkg::ST_FETCH: begin
            if (ptr_ff < count_ff) begin
               state_in = srjl_pkg::ST_CMP;
            end else begin
               rval_in  = '0;
               found_in = 1'b0;
               state_in = srjl_pkg::ST_DONE;
            end
         end
         srjl_pkg::ST_CMP: begin
            priority if (below_lower) begin
               rval_in  = '0;
               found_in = 1'b0;
               state_in = srjl_pkg::ST_DONE;
            end else if (below_upper) begin
               rval_in  = use_from_value ? tbl_rd.value : $signed(ptr_ext);
               found_in = 1'b1;
               state_in = srjl_pkg::ST_DONE;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = srjl_pkg::ST_FETCH;
            end
         end
         srjl_pkg::ST_DONE: begin
            if (res_ack) begin
               state_in = srjl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srjl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srjl_pkg::ST_IDLE;
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      rval_ff  <= rval_in;
      found_ff <= found_in;
   end

   assign res.valid = (state_ff == srjl_pkg::ST_DONE);
   assign res.value = rval_ff;
   assign res.found = found_ff;

endmodule

// File: sv/sorted_range_join_lookup.sv
// ----------------------------------------------------------------------------
// sorted_range_join_lookup
// Holds a table of up to 1024 half-open ranges [lower, upper) with attached
// values and answers an ascending stream of probe keys by a forward walk.
// ----------------------------------------------------------------------------
// Clear and append transfers give no result and leave the block ready. A probe
// that finds the walk pointer already at the end of the table misses without
// a compare; otherwise each step of its walk reads the entry at the pointer
// from the table memory (one registered read port) and then runs the signed
// lower and upper bound comparators. As the pointer only moves forward and
// only a clear or reset sets it back, a stream of probes steps past each entry
// at most once. The block is not ready while a probe walks, and the result sits
// in an output register so the next transfer can be taken while it waits. A hit
// returns the attached value when use_from_value is set, else the range index; a
// miss returns 0 with found low.
module sorted_range_join_lookup (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,   // use_from_value
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,     // range_lower, range_upper, range_value, probe_key
   input  logic [1:0]   req_tuser,     // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,     // result_value
   output logic         rsp_tuser      // found
);

   logic                             use_from_value_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [srjl_pkg::DATA_W-1:0] rsp_value_ff;
   logic                             rsp_found_ff;
   logic                             res_ack;

   srjl_pkg::tbl_wr_type             tbl_wr;
   srjl_pkg::tbl_rd_type             tbl_rd;
   logic [srjl_pkg::ADDR_W-1:0]      tbl_rd_addr;
   srjl_pkg::walk_res_type           res;

   srjl_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (tbl_rd_addr),
      .rd      (tbl_rd)
   );

   srjl_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (req_tvalid),
      .cmd_ready      (req_tready),
      .cmd_kind       (req_tuser),
      .cmd_lower      ($signed(req_tdata[31:0])),
      .cmd_upper      ($signed(req_tdata[63:32])),
      .cmd_value      ($signed(req_tdata[95:64])),
      .cmd_key        ($signed(req_tdata[127:96])),
      .use_from_value (use_from_value_ff),
      .tbl_wr         (tbl_wr),
      .tbl_rd_addr    (tbl_rd_addr),
      .tbl_rd         (tbl_rd),
      .res            (res),
      .res_ack        (res_ack)
   );

   assign res_ack = res.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_from_value_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            use_from_value_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ack) begin
         rsp_value_ff <= res.value;
         rsp_found_ff <= res.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

// File: sim/sorted_range_join_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_join_lookup_tb
// Self-checking bench for the sorted range join lookup. Range tables are
// loaded with clear and append transfers, and ascending probe streams are
// then run against them. A scoreboard keeps its own copy of the table, the
// walk pointer and the result mode, predicts every probe result, and
// compares it with what the block returns. Both sides are randomly throttled.
// ----------------------------------------------------------------------------
module sorted_range_join_lookup_tb;

   localparam int QUIET_LIMIT = 12000;
   localparam int RANDOM_ITEMS = 1200;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

   class range_lookup_board;
      logic signed [31:0] lower_bounds [srjl_pkg::MAX_RANGES];
      logic signed [31:0] upper_bounds [srjl_pkg::MAX_RANGES];
      logic signed [31:0] range_values [srjl_pkg::MAX_RANGES];
      int unsigned range_count;
      int unsigned walk_ptr;
      bit use_value;
      logic signed [31:0] expected_values [$];
      logic expected_found [$];
      int errors;

      function void clear_all();
         range_count = 0;
         walk_ptr = 0;
         use_value = 1'b0;
         errors = 0;
         expected_values.delete();
         expected_found.delete();
      endfunction

      function void set_mode(bit v);
         use_value = v;
      endfunction

      function int pending();
         return expected_values.size();
      endfunction

      function void take_request(logic [1:0] kind, logic signed [31:0] lo,
                                 logic signed [31:0] hi, logic signed [31:0] val,
                                 logic signed [31:0] key);
         bit searching;
         bit hit;
         logic signed [31:0] res;
         if (kind == srjl_pkg::KIND_CLEAR) begin
            range_count = 0;
            walk_ptr = 0;
         end else if (kind == srjl_pkg::KIND_APPEND) begin
            if (range_count < srjl_pkg::MAX_RANGES) begin
               lower_bounds[range_count] = lo;
               upper_bounds[range_count] = hi;
               range_values[range_count] = val;
               range_count++;
            end
         end else if (kind == srjl_pkg::KIND_PROBE) begin
            hit = 1'b0;
            res = '0;
            searching = 1'b1;
            while (searching && walk_ptr < range_count) begin
               if (key < lower_bounds[walk_ptr]) begin
                  searching = 1'b0;
               end else if (key < upper_bounds[walk_ptr]) begin
                  hit = 1'b1;
                  res = use_value ? range_values[walk_ptr] : 32'(walk_ptr);
                  searching = 1'b0;
               end else begin
                  walk_ptr++;
               end
            end
            expected_values.push_back(res);
            expected_found.push_back(hit);
         end
      endfunction

      function void check_result(logic signed [31:0] value, logic found);
         logic signed [31:0] exp_value;
         logic exp_found;
         if (expected_values.size() == 0) begin
            $error("result with none expected: result_value %0d found %0d", value, found);
            errors++;
            return;
         end
         exp_value = expected_values.pop_front();
         exp_found = expected_found.pop_front();
         if (found !== exp_found) begin
            $error("found: expected %0d, actual %0d", exp_found, found);
            errors++;
         end
         if (value !== exp_value) begin
            $error("result_value: expected %0d, actual %0d", exp_value, value);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic         csr_wr_data = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;    // range_lower, range_upper, range_value, probe_key
   logic [1:0]   req_tuser = '0;    // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;         // result_value
   logic         rsp_tuser;         // found

   range_lookup_board board;
   bit idle_on = 1'b0;
   int items_sent = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   sorted_range_join_lookup dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[sorted_range_join_lookup] ERROR");
            $finish;
         end
      end
   end

   // entered and left at a falling edge; tvalid stays high between back-to-back transfers
   task automatic send_item(input logic [1:0] kind, input logic signed [31:0] lo,
                            input logic signed [31:0] hi, input logic signed [31:0] val,
                            input logic signed [31:0] key);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {key, val, hi, lo};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_request(kind, lo, hi, val, key);
      if (kind != srjl_pkg::KIND_NONE)
         items_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_mode(input bit v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      board.set_mode(v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic probe(input logic signed [31:0] key);
      send_item(srjl_pkg::KIND_PROBE, $urandom, $urandom, $urandom, key);
   endtask

   task automatic run_join_phase(input int n_ranges, input int n_probes, input bit noisy);
      int bounds [$];
      int keys [$];
      int tmp;
      int r;
      bounds.delete();
      keys.delete();
      for (int i = 0; i < 2 * n_ranges; i++)
         bounds.push_back($urandom);
      bounds.sort();
      for (int i = 0; i < n_ranges; i++) begin
         if (i > 0 && $urandom_range(0, 3) == 0)
            bounds[2*i] = bounds[2*i-1];
         if ($urandom_range(0, 7) == 0)
            bounds[2*i+1] = bounds[2*i];
      end
      if (noisy) begin
         for (int i = 1; i < n_ranges; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               tmp = bounds[2*i];   bounds[2*i] = bounds[2*i-2];   bounds[2*i-2] = tmp;
               tmp = bounds[2*i+1]; bounds[2*i+1] = bounds[2*i-1]; bounds[2*i-1] = tmp;
            end
         end
      end
      send_item(srjl_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < n_ranges; i++) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_item(srjl_pkg::KIND_NONE, $urandom, $urandom, $urandom, $urandom);
         send_item(srjl_pkg::KIND_APPEND, bounds[2*i], bounds[2*i+1], $urandom, $urandom);
      end
      for (int j = 0; j < n_probes; j++) begin
         r = $urandom_range(0, n_ranges - 1);
         case ($urandom_range(0, 4))
            0: keys.push_back($urandom);
            1: keys.push_back(bounds[2*r]);
            2: keys.push_back(bounds[2*r+1] - 1);
            3: keys.push_back(bounds[2*r+1]);
            default: keys.push_back(bounds[2*r] + $urandom_range(0, 3));
         endcase
      end
      keys.sort();
      if (noisy) begin
         for (int j = 1; j < n_probes; j++) begin
            if ($urandom_range(0, 7) == 0) begin
               tmp = keys[j]; keys[j] = keys[j-1]; keys[j-1] = tmp;
            end
         end
      end
      for (int j = 0; j < n_probes; j++) begin
         if (noisy && $urandom_range(0, 19) == 0)
            send_item(srjl_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
         if (noisy && $urandom_range(0, 9) == 0)
            send_item(srjl_pkg::KIND_NONE, $urandom, $urandom, $urandom, $urandom);
         probe(keys[j]);
      end
   endtask

   initial begin
      int phase;
      board = new();
      board.clear_all();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: bound extremes, empty range, misses in gaps, past the end, ignored kind
      write_mode(1'b1);
      probe(KEY_MIN);
      send_item(srjl_pkg::KIND_NONE, KEY_MAX, KEY_MIN, KEY_MAX, KEY_MIN);
      send_item(srjl_pkg::KIND_APPEND, KEY_MIN, KEY_MIN + 5, KEY_MAX, '0);
      send_item(srjl_pkg::KIND_APPEND, 32'sd10, 32'sd10, 32'sd1, '1);
      send_item(srjl_pkg::KIND_APPEND, 32'sd20, KEY_MAX, KEY_MIN, KEY_MAX);
      probe(KEY_MIN);
      probe(KEY_MIN + 4);
      probe(KEY_MIN + 5);
      probe(32'sd10);
      probe(32'sd25);
      probe(KEY_MAX);
      probe(32'sd0);
      send_item(srjl_pkg::KIND_CLEAR, '1, '1, '1, '1);
      send_item(srjl_pkg::KIND_APPEND, 32'sd100, 32'sd200, 32'sd5, '0);
      send_item(srjl_pkg::KIND_APPEND, 32'sd0, 32'sd50, -32'sd6, '0);
      probe(32'sd10);
      probe(32'sd150);
      send_item(srjl_pkg::KIND_NONE, '0, '0, '0, '0);
      probe(32'sd300);
      settle();
      write_mode(1'b0);
      send_item(srjl_pkg::KIND_CLEAR, '0, '0, '0, '0);
      send_item(srjl_pkg::KIND_APPEND, -32'sd4, 32'sd4, 32'sd77, '0);
      send_item(srjl_pkg::KIND_APPEND, 32'sd4, 32'sd9, 32'sd78, '0);
      probe(-32'sd1);
      probe(32'sd4);
      probe(32'sd8);
      settle();

      // fill past capacity so the last appends are dropped
      idle_on = 1'b1;
      write_mode(1'b0);
      run_join_phase(srjl_pkg::MAX_RANGES + 3, 40, 1'b0);
      probe(KEY_MAX);
      settle();

      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         idle_on = (items_sent < RANDOM_ITEMS - 60) ? ($urandom_range(0, 3) != 0) : 1'b0;
         write_mode(phase[0]);
         run_join_phase(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                    : $urandom_range(1, 12),
                        $urandom_range(1, 30), $urandom_range(0, 2) == 0);
         settle();
         phase++;
      end

      repeat (16) @(negedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("[sorted_range_join_lookup] OK");
      else
         $display("[sorted_range_join_lookup] ERROR");
      $finish;
   end
endmodule
